### design/tsc_pkg.sv
`default_nettype none

package tsc_pkg;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BASELINE        = 3'd0,
    REG_TOUCH_LEVEL     = 3'd1,
    REG_NOISE_BAND      = 3'd2,
    REG_DEBOUNCE_LIMIT  = 3'd3,
    REG_IDLE_LIMIT      = 3'd4,
    REG_STUCK_LIMIT     = 3'd5,
    REG_HIGH_RAIL_LIMIT = 3'd6,
    REG_LOW_RAIL_LIMIT  = 3'd7
  } cfg_reg_e;

  // counter and limit widths
  localparam int unsigned DEB_W   = 4;
  localparam int unsigned IDLE_W  = 10;
  localparam int unsigned STUCK_W = 10;
  localparam int unsigned RAIL_W  = 8;

  // reset values of the limit registers
  localparam int unsigned      TOUCH_LEVEL_RST = 100;
  localparam int unsigned      NOISE_BAND_RST  = 30;
  localparam logic [DEB_W-1:0]   DEB_RST   = 4'd3;
  localparam logic [IDLE_W-1:0]  IDLE_RST  = 10'd100;
  localparam logic [STUCK_W-1:0] STUCK_RST = 10'd300;
  localparam logic [RAIL_W-1:0]  RAIL_RST  = 8'd50;

  // filter coefficient, q16
  localparam int unsigned ALPHA_Q16 = 13107;

  // result buffer
  localparam int unsigned OUT_DEPTH = 8;
  localparam int unsigned OUT_PTR_W = 3;
  localparam int unsigned OCC_W     = 4;

  // per-item control flags that ride along the pipeline
  typedef struct packed {
    logic vld;
    logic upd;
    logic fault;
  } ctl_t;

endpackage

`default_nettype wire

### design/tsc_fault_mon.sv
`default_nettype none

module tsc_fault_mon #(
  parameter int unsigned SB = 12
) (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire                            accept_i,
  input  wire  [SB-1:0]                  sample_i,
  input  wire                            load_i,
  input  wire  [tsc_pkg::STUCK_W-1:0]    stuck_limit_i,
  input  wire  [tsc_pkg::RAIL_W-1:0]     high_limit_i,
  input  wire  [tsc_pkg::RAIL_W-1:0]     low_limit_i,
  output logic                           fault_o
);
  import tsc_pkg::*;

  logic [SB-1:0]      prev_q;
  logic [STUCK_W-1:0] same_q, same_d;
  logic [RAIL_W-1:0]  high_q, high_d;
  logic [RAIL_W-1:0]  low_q, low_d;
  logic               fault_q, fault_d;

  always_comb begin
    if (sample_i == prev_q) begin
      same_d = (same_q == '1) ? same_q : same_q + 1'b1;
    end else begin
      same_d = '0;
    end
    if (sample_i == '1) begin
      high_d = (high_q == '1) ? high_q : high_q + 1'b1;
    end else begin
      high_d = '0;
    end
    if (sample_i == '0) begin
      low_d = (low_q == '1) ? low_q : low_q + 1'b1;
    end else begin
      low_d = '0;
    end
    // a cleared run count never exceeds its limit
    fault_d = fault_q | (same_d > stuck_limit_i) | (high_d > high_limit_i)
            | (low_d > low_limit_i);
  end

  assign fault_o = fault_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q  <= '0;
      same_q  <= '0;
      high_q  <= '0;
      low_q   <= '0;
      fault_q <= 1'b0;
    end else if (load_i) begin
      same_q  <= '0;
      high_q  <= '0;
      low_q   <= '0;
      fault_q <= 1'b0;
    end else if (accept_i) begin
      prev_q  <= sample_i;
      same_q  <= same_d;
      high_q  <= high_d;
      low_q   <= low_d;
      fault_q <= fault_d;
    end
  end

endmodule

`default_nettype wire

### design/tsc_avg_filter.sv
`default_nettype none

module tsc_avg_filter #(
  parameter int unsigned SB = 12,
  parameter int unsigned W  = 20
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  tsc_pkg::ctl_t        ctl_in_i,
  input  tsc_pkg::ctl_t        ctl0_i,
  input  tsc_pkg::ctl_t        ctl1_i,
  input  tsc_pkg::ctl_t        ctl2_i,
  input  wire  [SB-1:0]        sample_i,
  input  wire                  load_i,
  input  wire  [SB-1:0]        load_val_i,
  input  wire  [SB-1:0]        baseline_i,
  output logic [SB-1:0]        avg_o,
  output logic [SB-1:0]        smooth_o
);
  import tsc_pkg::*;

  localparam int unsigned SLOT_W    = (W > 1) ? $clog2(W) : 1;
  localparam int unsigned SUM_W     = SB + $clog2(W);
  localparam int unsigned DIV_SHIFT = SUM_W + $clog2(W);
  localparam int unsigned K_W       = SUM_W + 2;
  localparam int unsigned PROD_W    = SUM_W + K_W;
  // ceil(2^DIV_SHIFT / W): exact quotient for every sum below 2^SUM_W
  localparam longint unsigned DIV_K_L =
    ((longint'(1) << DIV_SHIFT) + longint'(W) - 1) / longint'(W);
  localparam logic [K_W-1:0]    DIV_K     = K_W'(DIV_K_L);
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(W - 1);
  localparam logic signed [SB+16:0] ALPHA_S = (SB+17)'(ALPHA_Q16);

  // window storage, entries not yet written read as the baseline
  logic [SB-1:0]     win_mem [W];
  logic [W-1:0]      win_vld_q;

  logic [SLOT_W-1:0] slot_q;
  logic [SLOT_W-1:0] s0_slot_q;
  logic [SB-1:0]     s0_sample_q;
  logic [SB-1:0]     rd_data_q;
  logic              rd_vld_q;
  logic              fwd_q;
  logic [SB-1:0]     fwd_data_q;
  logic [SB-1:0]     old_val;
  logic              wr_en;

  logic [SUM_W-1:0]  sum_q;
  logic [PROD_W-1:0] div_prod;
  logic [SB-1:0]     avg_q;
  logic [SB-1:0]     avg3_q;

  logic [SB-1:0]          f_q, f_d;
  logic signed [SB:0]     diff;
  logic signed [SB+16:0]  diff_ext;
  logic signed [SB+16:0]  ema_prod;
  logic signed [SB+16:0]  ema_step;

  assign wr_en = ctl0_i.vld & ctl0_i.upd;

  // read at accept, write in the cycle after
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      win_mem[s0_slot_q] <= s0_sample_q;
    end
    if (ctl_in_i.vld) begin
      rd_data_q   <= win_mem[slot_q];
      s0_sample_q <= sample_i;
      s0_slot_q   <= slot_q;
      fwd_data_q  <= s0_sample_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_vld_q <= '0;
      slot_q    <= '0;
      rd_vld_q  <= 1'b0;
      fwd_q     <= 1'b0;
    end else if (load_i) begin
      win_vld_q <= '0;
      slot_q    <= '0;
    end else begin
      if (wr_en) begin
        win_vld_q[s0_slot_q] <= 1'b1;
      end
      if (ctl_in_i.vld) begin
        rd_vld_q <= win_vld_q[s0_slot_q == slot_q ? s0_slot_q : slot_q];
        // same entry written on the read edge: take the new sample
        fwd_q    <= wr_en && (s0_slot_q == slot_q);
        if (ctl_in_i.upd) begin
          slot_q <= (slot_q == LAST_SLOT) ? '0 : slot_q + 1'b1;
        end
      end
    end
  end

  assign old_val = fwd_q ? fwd_data_q : (rd_vld_q ? rd_data_q : baseline_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
    end else if (load_i) begin
      sum_q <= SUM_W'(load_val_i) * SUM_W'(W);
    end else if (wr_en) begin
      sum_q <= sum_q - SUM_W'(old_val) + SUM_W'(s0_sample_q);
    end
  end

  // divide by the window length through a reciprocal multiply
  assign div_prod = PROD_W'(sum_q) * PROD_W'(DIV_K);

  always_ff @(posedge clk_i) begin
    if (ctl1_i.vld) begin
      avg_q <= div_prod[DIV_SHIFT +: SB];
    end
    if (ctl2_i.vld) begin
      avg3_q <= avg_q;
    end
  end

  // f + floor(alpha * (avg - f) / 2^16)
  always_comb begin
    diff     = $signed({1'b0, avg_q}) - $signed({1'b0, f_q});
    diff_ext = {{16{diff[SB]}}, diff};
    ema_prod = diff_ext * ALPHA_S;
    ema_step = ema_prod >>> 16;
    f_d      = f_q + ema_step[SB-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_q <= '0;
    end else if (load_i) begin
      f_q <= load_val_i;
    end else if (ctl2_i.vld && ctl2_i.upd) begin
      f_q <= f_d;
    end
  end

  assign avg_o    = avg3_q;
  assign smooth_o = f_q;

endmodule

`default_nettype wire

### design/tsc_touch_track.sv
`default_nettype none

module tsc_touch_track #(
  parameter int unsigned SB = 12
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  tsc_pkg::ctl_t                ctl_i,
  input  wire                          load_i,
  input  wire  [SB-1:0]                smooth_i,
  input  wire  [SB-1:0]                baseline_i,
  input  wire  [SB-1:0]                touch_level_i,
  input  wire  [SB-1:0]                noise_band_i,
  input  wire  [tsc_pkg::DEB_W-1:0]    debounce_limit_i,
  input  wire  [tsc_pkg::IDLE_W-1:0]   idle_limit_i,
  output logic                         event_o,
  output logic                         saving_o,
  output logic                         lock_o
);
  import tsc_pkg::*;

  logic [IDLE_W-1:0] idle_q, idle_d;
  logic              saving_q, saving_d;
  logic [DEB_W-1:0]  touched_q, touched_d;
  logic [DEB_W-1:0]  released_q, released_d;
  logic              lock_q, lock_d;
  logic              evt;
  logic [SB-1:0]     gap;
  logic              near;
  logic              below;

  always_comb begin
    gap   = (smooth_i >= baseline_i) ? smooth_i - baseline_i : baseline_i - smooth_i;
    near  = gap <= noise_band_i;
    below = smooth_i < touch_level_i;

    idle_d     = idle_q;
    saving_d   = saving_q;
    touched_d  = touched_q;
    released_d = released_q;
    lock_d     = lock_q;
    evt        = 1'b0;

    if (ctl_i.upd) begin
      // idle tracking
      if (!saving_q) begin
        if (near) begin
          idle_d = (idle_q == '1) ? idle_q : idle_q + 1'b1;
          if (idle_d >= idle_limit_i) begin
            saving_d = 1'b1;
          end
        end else begin
          idle_d = '0;
        end
      end else if (below) begin
        saving_d = 1'b0;
        idle_d   = '0;
      end

      // debounce with release lock
      if (!lock_q) begin
        if (below && !near) begin
          touched_d  = (touched_q == '1) ? touched_q : touched_q + 1'b1;
          released_d = '0;
          if (touched_d >= debounce_limit_i) begin
            evt = 1'b1;
          end
        end else begin
          released_d = (released_q == '1) ? released_q : released_q + 1'b1;
          if (released_d >= debounce_limit_i) begin
            touched_d  = '0;
            released_d = debounce_limit_i;
          end
        end
        if (evt) begin
          touched_d  = '0;
          released_d = '0;
          lock_d     = 1'b1;
        end
      end else if (!below) begin
        lock_d     = 1'b0;
        touched_d  = '0;
        released_d = '0;
      end
    end
  end

  assign event_o  = evt;
  assign saving_o = saving_d;
  assign lock_o   = lock_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idle_q     <= '0;
      saving_q   <= 1'b0;
      touched_q  <= '0;
      released_q <= '0;
      lock_q     <= 1'b0;
    end else if (load_i) begin
      idle_q   <= '0;
      saving_q <= 1'b0;
    end else if (ctl_i.vld) begin
      idle_q     <= idle_d;
      saving_q   <= saving_d;
      touched_q  <= touched_d;
      released_q <= released_d;
      lock_q     <= lock_d;
    end
  end

endmodule

`default_nettype wire

### design/tsc_out_fifo.sv
`default_nettype none

module tsc_out_fifo #(
  parameter int unsigned WIDTH = 28
) (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  input  wire                         push_i,
  input  wire  [WIDTH-1:0]            data_i,
  input  wire                         pop_i,
  output logic [WIDTH-1:0]            data_o,
  output logic                        valid_o,
  output logic [tsc_pkg::OCC_W-1:0]   level_o
);
  import tsc_pkg::*;

  logic [WIDTH-1:0]     buf_q [OUT_DEPTH];
  logic [OUT_PTR_W-1:0] wr_ptr_q;
  logic [OUT_PTR_W-1:0] rd_ptr_q;
  logic [OCC_W-1:0]     cnt_q;
  logic                 do_pop;

  assign valid_o = cnt_q != '0;
  assign do_pop  = pop_i && valid_o;
  assign data_o  = buf_q[rd_ptr_q];
  assign level_o = cnt_q;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      buf_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      cnt_q <= cnt_q + OCC_W'(push_i) - OCC_W'(do_pop);
    end
  end

endmodule

`default_nettype wire

### design/touch_sample_conditioner_core.sv
// touch sample conditioner
// input channel: in_valid_i / in_stall_o with one raw sample per beat
// output channel: out_valid_o / out_stall_i, exactly one result beat per input beat,
// in order: fault, touch_event, power_save, awaiting_release, average, smoothed
// configuration: cfg_we_i writes cfg_data_i into the register cfg_idx_i. write
// only while no beats are in flight. a baseline write reloads the
// window, sum and filter on the spot (per-entry valid bits, no clearing pass)
// throughput: one beat per cycle while in_stall_o is low. the filter recurrence
// closes through one multiplier and the f_q register, and the window memory is read
// the cycle the sample is accepted, written back the next
// path: the accepting edge loads ctl_q[0], the beat moves on to ctl_q[3] and is pushed into the result buffer
// stall: up to 8 beats (pipeline plus result buffer) can be in flight; in_stall_o
// rises once 8 are held, so a stalled receiver never drops or repeats a beat
// reset: registers take their documented defaults, window reads as baseline 0,
// counters, fault, power save and release lock clear
`default_nettype none

module touch_sample_conditioner_core #(
  parameter int unsigned WINDOW_LEN  = 20,
  parameter int unsigned SAMPLE_BITS = 12
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  // sample channel
  input  wire                              in_valid_i,
  output logic                             in_stall_o,
  input  wire  [SAMPLE_BITS-1:0]           sample_i,
  // result channel
  output logic                             out_valid_o,
  input  wire                              out_stall_i,
  output logic                             fault_o,
  output logic                             touch_event_o,
  output logic                             power_save_o,
  output logic                             awaiting_release_o,
  output logic [SAMPLE_BITS-1:0]           average_o,
  output logic [SAMPLE_BITS-1:0]           smoothed_o,
  // configuration
  input  wire                              cfg_we_i,
  input  wire  [tsc_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  wire  [((SAMPLE_BITS > 10) ? SAMPLE_BITS : 10)-1:0] cfg_data_i
);
  import tsc_pkg::*;

  localparam int unsigned SB         = SAMPLE_BITS;
  localparam int unsigned RES_W      = 4 + 2 * SB;
  localparam int unsigned CTL_STAGES = 4;

  // configuration registers
  logic [SB-1:0]      baseline_q;
  logic [SB-1:0]      touch_level_q;
  logic [SB-1:0]      noise_band_q;
  logic [DEB_W-1:0]   debounce_limit_q;
  logic [IDLE_W-1:0]  idle_limit_q;
  logic [STUCK_W-1:0] stuck_limit_q;
  logic [RAIL_W-1:0]  high_limit_q;
  logic [RAIL_W-1:0]  low_limit_q;
  logic               load;

  // handshake and occupancy
  logic               accept;
  logic               take;
  logic [OCC_W-1:0]   occ_q;

  // pipeline control
  ctl_t               ctl_in;
  ctl_t               ctl_q [CTL_STAGES];
  logic               fault_n;

  // datapath
  logic [SB-1:0]      avg;
  logic [SB-1:0]      smooth;
  logic               evt;
  logic               saving;
  logic               lock;
  logic [RES_W-1:0]   res_in;
  logic [RES_W-1:0]   res_out;
  logic [OCC_W-1:0]   fifo_level;

  assign load = cfg_we_i && (cfg_reg_e'(cfg_idx_i) == REG_BASELINE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      baseline_q       <= '0;
      touch_level_q    <= SB'(TOUCH_LEVEL_RST);
      noise_band_q     <= SB'(NOISE_BAND_RST);
      debounce_limit_q <= DEB_RST;
      idle_limit_q     <= IDLE_RST;
      stuck_limit_q    <= STUCK_RST;
      high_limit_q     <= RAIL_RST;
      low_limit_q      <= RAIL_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_BASELINE:        baseline_q       <= cfg_data_i[SB-1:0];
        REG_TOUCH_LEVEL:     touch_level_q    <= cfg_data_i[SB-1:0];
        REG_NOISE_BAND:      noise_band_q     <= cfg_data_i[SB-1:0];
        REG_DEBOUNCE_LIMIT:  debounce_limit_q <= cfg_data_i[DEB_W-1:0];
        REG_IDLE_LIMIT:      idle_limit_q     <= cfg_data_i[IDLE_W-1:0];
        REG_STUCK_LIMIT:     stuck_limit_q    <= cfg_data_i[STUCK_W-1:0];
        REG_HIGH_RAIL_LIMIT: high_limit_q     <= cfg_data_i[RAIL_W-1:0];
        REG_LOW_RAIL_LIMIT:  low_limit_q      <= cfg_data_i[RAIL_W-1:0];
      endcase
    end
  end

  // credit scheme: every beat in the pipe has a reserved buffer slot, so the
  // pipe itself never stalls
  assign in_stall_o = occ_q == OCC_W'(OUT_DEPTH);
  assign accept     = in_valid_i && !in_stall_o;
  assign take       = out_valid_o && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= '0;
    end else begin
      occ_q <= occ_q + OCC_W'(accept) - OCC_W'(take);
    end
  end

  // fault run counters, resolved on the accepting edge
  tsc_fault_mon #(
    .SB (SB)
  ) u_fault (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .sample_i      (sample_i),
    .load_i        (load),
    .stuck_limit_i (stuck_limit_q),
    .high_limit_i  (high_limit_q),
    .low_limit_i   (low_limit_q),
    .fault_o       (fault_n)
  );

  // a faulted beat only carries the held state through
  assign ctl_in = '{vld: accept, upd: !fault_n, fault: fault_n};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CTL_STAGES; i++) begin
        ctl_q[i] <= '0;
      end
    end else begin
      ctl_q[0] <= ctl_in;
      for (int i = 1; i < CTL_STAGES; i++) begin
        ctl_q[i] <= ctl_q[i-1];
      end
    end
  end

  // window memory, running sum, divide and exponential filter
  tsc_avg_filter #(
    .SB (SB),
    .W  (WINDOW_LEN)
  ) u_avg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_in_i   (ctl_in),
    .ctl0_i     (ctl_q[0]),
    .ctl1_i     (ctl_q[1]),
    .ctl2_i     (ctl_q[2]),
    .sample_i   (sample_i),
    .load_i     (load),
    .load_val_i (cfg_data_i[SB-1:0]),
    .baseline_i (baseline_q),
    .avg_o      (avg),
    .smooth_o   (smooth)
  );

  // idle tracking and touch debounce on the new filter value
  tsc_touch_track #(
    .SB (SB)
  ) u_touch (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .ctl_i            (ctl_q[3]),
    .load_i           (load),
    .smooth_i         (smooth),
    .baseline_i       (baseline_q),
    .touch_level_i    (touch_level_q),
    .noise_band_i     (noise_band_q),
    .debounce_limit_i (debounce_limit_q),
    .idle_limit_i     (idle_limit_q),
    .event_o          (evt),
    .saving_o         (saving),
    .lock_o           (lock)
  );

  assign res_in = {ctl_q[3].fault, evt, saving, lock, avg, smooth};

  // result buffer decouples the receiver from the pipe
  tsc_out_fifo #(
    .WIDTH (RES_W)
  ) u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (ctl_q[3].vld),
    .data_i  (res_in),
    .pop_i   (!out_stall_i),
    .data_o  (res_out),
    .valid_o (out_valid_o),
    .level_o (fifo_level)
  );

  assign fault_o            = res_out[RES_W-1];
  assign touch_event_o      = res_out[RES_W-2];
  assign power_save_o       = res_out[RES_W-3];
  assign awaiting_release_o = res_out[RES_W-4];
  assign average_o          = res_out[2*SB-1:SB];
  assign smoothed_o         = res_out[SB-1:0];

  // credit count matches beats in the pipe plus beats buffered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(occ_q) == $countones({ctl_q[3].vld, ctl_q[2].vld, ctl_q[1].vld, ctl_q[0].vld})
                   + int'(fifo_level))
    else $error("occupancy count out of step with pipeline and buffer");

  // a beat leaving the pipe always finds room
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_q[3].vld |-> (fifo_level < OCC_W'(OUT_DEPTH)))
    else $error("result buffer overflow");

  // the fault latch cannot drop between beats without a reload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl_q[1].vld && ctl_q[0].vld && ctl_q[1].fault) |-> ctl_q[0].fault)
    else $error("fault latch dropped between beats");

  // a confirmed touch always arms the release lock
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && touch_event_o) |-> awaiting_release_o)
    else $error("touch event without release lock");

endmodule

`default_nettype wire
